### rtl/core/frame_difference_motion_gate_core_macros.svh
// assertion macros shared by the core
`ifndef FRAME_DIFFERENCE_MOTION_GATE_CORE_MACROS_SVH
`define FRAME_DIFFERENCE_MOTION_GATE_CORE_MACROS_SVH

`ifndef NO_ASSERTIONS
`define FDMG_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);
`define FDMG_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);
`else
`define FDMG_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg)
`define FDMG_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

### rtl/core/fdmg_pkg.sv
`timescale 1ns / 1ps
package fdmg_pkg;

  localparam int SampleCount  = 768;
  localparam int FrameLenBits = 20;
  localparam int SampleIdxW   = 10;
  localparam int CountW       = 10;
  localparam int CfgIdxW      = 1;
  localparam int CfgDataW     = 10;

  // stride = len / 768 = (len >> 8) / 3, the /3 by reciprocal
  localparam int StrideShift  = 8;
  localparam int LenHiW       = FrameLenBits - StrideShift;
  localparam int RecipShift   = 13;
  localparam int Recip        = (1 << RecipShift) / 3 + 1;
  localparam int RecipW       = RecipShift;
  localparam int ProdW        = LenHiW + RecipW;

  localparam logic [CountW-1:0] CountMax = '1;

  localparam logic [CfgIdxW-1:0] CfgChangeThr = 1'd0;
  localparam logic [CfgIdxW-1:0] CfgMotionThr = 1'd1;

  localparam logic [7:0]        ChangeThrReset = 8'd24;
  localparam logic [CountW-1:0] MotionThrReset = 10'd77;

  typedef struct packed {
    logic [7:0]              data_byte;
    logic [FrameLenBits-1:0] frame_len;
    logic                    last_byte;
  } in_t;

  typedef struct packed {
    logic [CountW-1:0] change_count;
    logic              motion_detected;
    logic              reference_only;
  } out_t;

  typedef struct packed {
    logic [7:0]        change_threshold;
    logic [CountW-1:0] motion_count_threshold;
  } cfg_t;

  typedef struct packed {
    logic                  sample;
    logic [SampleIdxW-1:0] idx;
    logic [7:0]            data;
    logic                  last;
    logic                  long_enough;
  } mid_t;

  function automatic logic [FrameLenBits-1:0] stride_of(input logic [FrameLenBits-1:0] len);
    logic [ProdW-1:0] prod;
    prod = ProdW'(len[FrameLenBits-1:StrideShift]) * ProdW'(Recip);
    return FrameLenBits'(prod[ProdW-1:RecipShift]);
  endfunction

endpackage

### rtl/core/frame_difference_motion_gate_core.sv
`timescale 1ns / 1ps
// Motion gate over the byte stream of a frame: one byte per transaction, 768 bytes sampled at
// a stride of frame_len / 768, each compared with the stored reference sample and then written
// back as the new reference; the byte marked last yields one result with the changed count and
// the motion flag. The block sustains one byte per clock unless a last byte waits on a full
// output queue; a result shows on the output queue once its last byte has passed the queue
// behind the front end, the sample memory read stage, and the compare, write back and result
// store of the back end. The first frame and frames shorter than 768 bytes report reference_only.
// Every frame must carry exactly frame_len bytes.
module frame_difference_motion_gate_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push,
  output logic                          full,
  input  fdmg_pkg::in_t                 in_data_i,
  output logic                          empty,
  input  logic                          pop,
  output fdmg_pkg::out_t                out_data_o,
  input  logic                          cfg_we_i,
  input  logic [fdmg_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [fdmg_pkg::CfgDataW-1:0] cfg_wdata_i
);

  fdmg_pkg::cfg_t cfg_q;
  fdmg_pkg::mid_t front_entry, mid_entry;
  logic           accept, mid_full, mid_empty, mid_pop;

  assign accept = push && !mid_full;
  assign full   = mid_full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.change_threshold       <= fdmg_pkg::ChangeThrReset;
      cfg_q.motion_count_threshold <= fdmg_pkg::MotionThrReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        fdmg_pkg::CfgChangeThr: cfg_q.change_threshold <= cfg_wdata_i[7:0];
        fdmg_pkg::CfgMotionThr: cfg_q.motion_count_threshold <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  fdmg_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .in_i     (in_data_i),
    .entry_o  (front_entry)
  );

  fdmg_mid_fifo u_mid_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (accept),
    .entry_i (front_entry),
    .full_o  (mid_full),
    .pop_i   (mid_pop),
    .empty_o (mid_empty),
    .entry_o (mid_entry)
  );

  fdmg_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .mid_valid_i (!mid_empty),
    .mid_i       (mid_entry),
    .mid_pop_o   (mid_pop),
    .res_empty_o (empty),
    .res_pop_i   (pop),
    .res_o       (out_data_o)
  );

endmodule

### rtl/core/fdmg_front.sv
`timescale 1ns / 1ps
module fdmg_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          accept_i,
  input  fdmg_pkg::in_t in_i,
  output fdmg_pkg::mid_t entry_o
);

  logic [fdmg_pkg::FrameLenBits-1:0] pos_q, pos_d, nxt_q, nxt_d;
  logic [fdmg_pkg::SampleIdxW-1:0]   sidx_q, sidx_d;
  logic                              long_enough;
  logic                              take;

  assign long_enough = in_i.frame_len >= fdmg_pkg::FrameLenBits'(fdmg_pkg::SampleCount);
  assign take = long_enough && (sidx_q < fdmg_pkg::SampleIdxW'(fdmg_pkg::SampleCount))
                && (pos_q == nxt_q);

  always_comb begin
    entry_o.sample      = take;
    entry_o.idx         = sidx_q;
    entry_o.data        = in_i.data_byte;
    entry_o.last        = in_i.last_byte;
    entry_o.long_enough = long_enough;
  end

  always_comb begin
    pos_d  = pos_q;
    nxt_d  = nxt_q;
    sidx_d = sidx_q;
    if (accept_i) begin
      pos_d = pos_q + 1'b1;
      if (take) begin
        sidx_d = sidx_q + 1'b1;
        nxt_d  = nxt_q + fdmg_pkg::stride_of(in_i.frame_len);
      end
      if (in_i.last_byte) begin
        pos_d  = '0;
        nxt_d  = '0;
        sidx_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      nxt_q  <= '0;
      sidx_q <= '0;
    end else begin
      pos_q  <= pos_d;
      nxt_q  <= nxt_d;
      sidx_q <= sidx_d;
    end
  end

endmodule

### rtl/core/fdmg_mid_fifo.sv
`timescale 1ns / 1ps
module fdmg_mid_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  fdmg_pkg::mid_t entry_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           empty_o,
  output fdmg_pkg::mid_t entry_o
);

  fdmg_pkg::mid_t slot_q [2];
  logic           wptr_q, rptr_q;
  logic [1:0]     cnt_q;
  logic           do_push, do_pop;

  assign full_o  = cnt_q == 2'd2;
  assign empty_o = cnt_q == 2'd0;
  assign entry_o = slot_q[rptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (do_push) wptr_q <= ~wptr_q;
      if (do_pop) rptr_q <= ~rptr_q;
      cnt_q <= cnt_q + 2'(do_push) - 2'(do_pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) slot_q[wptr_q] <= entry_i;
  end

endmodule

### rtl/core/fdmg_back.sv
`timescale 1ns / 1ps
`include "frame_difference_motion_gate_core_macros.svh"
module fdmg_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  fdmg_pkg::cfg_t  cfg_i,
  input  logic            mid_valid_i,
  input  fdmg_pkg::mid_t  mid_i,
  output logic            mid_pop_o,
  output logic            res_empty_o,
  input  logic            res_pop_i,
  output fdmg_pkg::out_t  res_o
);

  logic [7:0]     mem [fdmg_pkg::SampleCount];
  fdmg_pkg::mid_t b1_q;
  logic           b1_valid_q;
  logic [7:0]     rdata_q, fwd_byte_q;
  logic           fwd_q;
  logic           have_ref_q;
  logic [fdmg_pkg::CountW-1:0] total_q, total_nx;

  fdmg_pkg::out_t res_slot_q [2];
  logic           res_wptr_q, res_rptr_q;
  logic [1:0]     res_cnt_q;
  logic           res_full, res_push, res_pop;
  fdmg_pkg::out_t res_new;

  logic       exec_fire, issue, inc;
  logic [7:0] ref_byte, diff;
  logic       counted;
  logic [fdmg_pkg::CountW-1:0] count;

  assign res_full    = res_cnt_q == 2'd2;
  assign res_empty_o = res_cnt_q == 2'd0;
  assign res_o       = res_slot_q[res_rptr_q];
  assign res_pop     = res_pop_i && !res_empty_o;

  assign exec_fire = b1_valid_q && !(b1_q.last && res_full);
  assign issue     = mid_valid_i && (!b1_valid_q || exec_fire);
  assign mid_pop_o = issue;
  assign res_push  = exec_fire && b1_q.last;

  assign ref_byte = fwd_q ? fwd_byte_q : rdata_q;
  assign diff     = (b1_q.data > ref_byte) ? b1_q.data - ref_byte : ref_byte - b1_q.data;
  assign inc      = b1_q.sample && have_ref_q && (diff > cfg_i.change_threshold)
                    && (total_q != fdmg_pkg::CountMax);
  assign total_nx = total_q + fdmg_pkg::CountW'(inc);
  assign counted  = b1_q.long_enough && have_ref_q;
  assign count    = counted ? total_nx : '0;

  always_comb begin
    res_new.change_count    = count;
    res_new.motion_detected = count >= cfg_i.motion_count_threshold;
    res_new.reference_only  = !counted;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b1_valid_q <= 1'b0;
      have_ref_q <= 1'b0;
      total_q    <= '0;
      res_wptr_q <= 1'b0;
      res_rptr_q <= 1'b0;
      res_cnt_q  <= 2'd0;
    end else begin
      if (issue) b1_valid_q <= 1'b1;
      else if (exec_fire) b1_valid_q <= 1'b0;
      if (exec_fire) begin
        if (b1_q.last) begin
          total_q <= '0;
          if (b1_q.long_enough) have_ref_q <= 1'b1;
        end else begin
          total_q <= total_nx;
        end
      end
      if (res_push) res_wptr_q <= ~res_wptr_q;
      if (res_pop) res_rptr_q <= ~res_rptr_q;
      res_cnt_q <= res_cnt_q + 2'(res_push) - 2'(res_pop);
    end
  end

  // read stage with bypass of the write issued in the same cycle
  always_ff @(posedge clk_i) begin
    if (issue) begin
      b1_q       <= mid_i;
      fwd_q      <= exec_fire && b1_q.sample && (b1_q.idx == mid_i.idx);
      fwd_byte_q <= b1_q.data;
      if (mid_i.sample) rdata_q <= mem[mid_i.idx];
    end
  end

  always_ff @(posedge clk_i) begin
    if (exec_fire && b1_q.sample) mem[b1_q.idx] <= b1_q.data;
  end

  always_ff @(posedge clk_i) begin
    if (res_push) res_slot_q[res_wptr_q] <= res_new;
  end

  `FDMG_ASSERT_IMPL(a_idx_range, clk_i, rst_ni, exec_fire && b1_q.sample,
    b1_q.idx < fdmg_pkg::SampleIdxW'(fdmg_pkg::SampleCount), "sample index out of range")
  `FDMG_ASSERT_IMPL(a_res_room, clk_i, rst_ni, res_push, !res_full, "result queue overflow")
  `FDMG_ASSERT_IMPL(a_ref_only_zero, clk_i, rst_ni, res_push && res_new.reference_only,
    res_new.change_count == '0, "reference-only result with nonzero count")
  `FDMG_ASSERT_NEXT(a_total_clear, clk_i, rst_ni, exec_fire && b1_q.last,
    total_q == '0, "change total not cleared at frame end")

endmodule
